// ===== rtl/core/tovu_pkg.sv =====
// ----------------------------------------------------------------------------
// Tracked object velocity update: shared package
// Field widths, item kinds and the structs that pass between the control
// logic, the two divider lanes and the merge stage.
// ----------------------------------------------------------------------------
package tovu_pkg;

   // Position and velocity fields are fixed by the stream format.
   localparam int POS_W       = 16;
   localparam int VEL_W       = POS_W + 1;
   localparam int STEP_W      = $clog2(POS_W);
   localparam int REQ_TDATA_W = 40;

   // Item kinds carried on req_tuser.
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_START = 1'b1;

   // Command to one divider lane: start strobe with the two positions.
   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] new_pos;
      logic [POS_W-1:0] old_pos;
   } lane_cmd_type;

   // Result of one divider lane.
   typedef struct packed {
      logic                    done;
      logic signed [VEL_W-1:0] vel;
   } lane_rsp_type;

endpackage

// ===== rtl/core/tovu_lane.sv =====
// ----------------------------------------------------------------------------
// Velocity divider lane
// Takes the difference of two positions and divides it by the frame count
// with a restoring divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module tovu_lane
   import tovu_pkg::*;
#(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lane_cmd_type           cmd,
   input  logic [COUNT_WIDTH-1:0] divisor,
   output lane_rsp_type           rsp
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(POS_W - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [POS_W-1:0]       quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] div_ff, div_in;
   logic                   neg_ff, neg_in;

   logic [VEL_W-1:0]       diff;
   logic [VEL_W-1:0]       mag;
   logic [COUNT_WIDTH:0]   shifted;
   logic [COUNT_WIDTH:0]   trial;
   logic                   fits;
   logic [VEL_W-1:0]       quo_ext;

   // Signed difference and its magnitude at the start of a division.
   assign diff = {1'b0, cmd.new_pos} - {1'b0, cmd.old_pos};
   assign mag  = diff[VEL_W-1] ? (~diff + VEL_W'(1)) : diff;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[POS_W-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = mag[POS_W-1:0];
         neg_in  = diff[VEL_W-1];
         // The counter is never zero; a zero divisor is taken as one.
         div_in  = (divisor == '0) ? COUNT_WIDTH'(1) : divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
         quo_in  = {quo_ff[POS_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // Apply the sign of the difference to the magnitude quotient.
   assign quo_ext  = {1'b0, quo_ff};
   assign rsp.done = done_ff;
   assign rsp.vel  = neg_ff ? (VEL_W'(0) - quo_ext) : quo_ext;

   // A finished division never overlaps a running one.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider lane reports done while still busy");

endmodule

// ===== rtl/core/tovu_merge.sv =====
// ----------------------------------------------------------------------------
// Lane merge and result stage
// Collects the velocities of both lanes into the velocity state and packs
// the track state into the result word register.
// ----------------------------------------------------------------------------
module tovu_merge
   import tovu_pkg::*;
#(
   parameter int HISTORY_LEN = 7,
   parameter int COUNT_WIDTH = 8,
   parameter int RSP_W       = 88
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear_vel,
   input  lane_rsp_type           lane_x,
   input  lane_rsp_type           lane_y,
   output logic                   lanes_done,
   input  logic                   load,
   output logic                   load_free,
   input  logic [POS_W-1:0]       pos_x,
   input  logic [POS_W-1:0]       pos_y,
   input  logic [HISTORY_LEN-1:0] history,
   input  logic [COUNT_WIDTH-1:0] count,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata
);

   logic [VEL_W-1:0] vel_x_ff, vel_x_in;
   logic [VEL_W-1:0] vel_y_ff, vel_y_in;
   logic             valid_ff, valid_in;
   logic [RSP_W-1:0] data_ff, data_in;

   // Both lanes start together and take the same number of steps.
   assign lanes_done = lane_x.done & lane_y.done;

   // Velocity state: cleared for a new track, taken from the lanes otherwise.
   always_comb begin
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      if (clear_vel) begin
         vel_x_in = '0;
         vel_y_in = '0;
      end else if (lanes_done) begin
         vel_x_in = lane_x.vel;
         vel_y_in = lane_y.vel;
      end
   end

   // Result word register; it can take a new word when empty or draining.
   assign load_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = RSP_W'({count, history, vel_y_ff, vel_x_ff, pos_y, pos_x});
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // The two lanes must always finish in the same cycle.
   assert property (@(posedge clock) disable iff (reset) lane_x.done == lane_y.done)
      else $error("velocity lanes finished in different cycles");

endmodule

// ===== rtl/core/tracked_object_velocity_update.sv =====
// ----------------------------------------------------------------------------
// Tracked object velocity update
// Follows one screen object from frame to frame: position, velocity per
// frame, visibility history and frames since the last sighting.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one word per frame. req_tuser selects a frame
//   update or the start of a new track; req_tdata carries the detected
//   position and the seen flag. For every request word the rsp channel
//   returns one word with the track state after that update.
//   A seen frame update runs the x and y velocity divisions in two lanes
//   side by side, one quotient bit per cycle; when both lanes are done,
//   the result word is loaded in the publish state once the output register
//   is free, and the next request word is taken back in the idle state.
//   Start words and unseen updates skip the divider and go straight to publish.
//   The result word sits in an output register, so a request is taken
//   while an earlier result waits; if rsp_tready stays low, the following
//   result waits in its state and req_tready stays low until it can move.
//   Reset clears the track to position 0, velocity 0, history showing seen
//   now only and a frame count of 1, and drops any pending result word.
// ----------------------------------------------------------------------------
module tracked_object_velocity_update
   import tovu_pkg::*;
#(
   parameter int HISTORY_LEN = 7,
   parameter int COUNT_WIDTH = 8,
   localparam int RSP_BITS   = 2 * POS_W + 2 * VEL_W + HISTORY_LEN + COUNT_WIDTH,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // new_x, new_y, seen
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic                   req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pos_x, pos_y, vel_x, vel_y, history, frames_unseen
   output logic [RSP_W-1:0]       rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready
);

   localparam logic [HISTORY_LEN-1:0] HIST_NEWEST = HISTORY_LEN'(1) << (HISTORY_LEN - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DIVIDE  = 3'b010,
      ST_PUBLISH = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_x_ff, pos_x_in;
   logic [POS_W-1:0]       pos_y_ff, pos_y_in;
   logic [HISTORY_LEN-1:0] hist_ff, hist_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [POS_W-1:0] new_x;
   logic [POS_W-1:0] new_y;
   logic             seen;
   logic             accept;
   logic             is_start;
   logic             seen_update;
   logic             lanes_done;
   logic             load_free;
   logic             load;
   lane_cmd_type     cmd_x;
   lane_cmd_type     cmd_y;
   lane_rsp_type     rsp_x;
   lane_rsp_type     rsp_y;

   // Request word fields.
   assign new_x = req_tdata[POS_W-1:0];
   assign new_y = req_tdata[2*POS_W-1:POS_W];
   assign seen  = req_tdata[2*POS_W];

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign is_start    = (req_tuser == KIND_START);
   assign seen_update = accept && !is_start && seen;
   assign load        = (state_ff == ST_PUBLISH) && load_free;

   // The lanes take the old position before it is replaced.
   assign cmd_x = '{start: seen_update, new_pos: new_x, old_pos: pos_x_ff};
   assign cmd_y = '{start: seen_update, new_pos: new_y, old_pos: pos_y_ff};

   // Track state update and sequencing.
   always_comb begin
      state_in = state_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      hist_in  = hist_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_start) begin
                  pos_x_in = new_x;
                  pos_y_in = new_y;
                  hist_in  = HIST_NEWEST;
                  count_in = COUNT_ONE;
                  state_in = ST_PUBLISH;
               end else if (seen) begin
                  pos_x_in = new_x;
                  pos_y_in = new_y;
                  hist_in  = (hist_ff >> 1) | HIST_NEWEST;
                  count_in = COUNT_ONE;
                  state_in = ST_DIVIDE;
               end else begin
                  hist_in  = hist_ff >> 1;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_ONE;
                  end
                  state_in = ST_PUBLISH;
               end
            end
         end
         ST_DIVIDE: begin
            if (lanes_done) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (load_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         hist_ff  <= HIST_NEWEST;
         count_ff <= COUNT_ONE;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         hist_ff  <= hist_in;
         count_ff <= count_in;
      end
   end

   // Velocity lanes, one per axis, sharing the frame count as divisor.
   tovu_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_x),
      .divisor(count_ff),
      .rsp    (rsp_x)
   );

   tovu_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_y),
      .divisor(count_ff),
      .rsp    (rsp_y)
   );

   // Merge of the lane results and the result word register.
   tovu_merge #(
      .HISTORY_LEN(HISTORY_LEN),
      .COUNT_WIDTH(COUNT_WIDTH),
      .RSP_W      (RSP_W)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .clear_vel (accept && is_start),
      .lane_x    (rsp_x),
      .lane_y    (rsp_y),
      .lanes_done(lanes_done),
      .load      (load),
      .load_free (load_free),
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .history   (hist_ff),
      .count     (count_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // The newest history bit is set exactly when the count has returned to one.
   assert property (@(posedge clock) disable iff (reset)
      hist_ff[HISTORY_LEN-1] == (count_ff == COUNT_ONE))
      else $error("history and frame count disagree");

   // The frame count never reaches zero.
   assert property (@(posedge clock) disable iff (reset) count_ff != '0)
      else $error("frame count is zero");

   // A start word never enters the divider.
   assert property (@(posedge clock) disable iff (reset)
      accept && is_start |=> state_ff == ST_PUBLISH)
      else $error("start word did not go straight to the result stage");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Tracked object velocity update: testbench
// Sends frame updates and track starts into the request stream and checks
// every response word against a track predictor that runs beside the block.
// Covers position extremes, negative and truncated velocities, counter
// saturation, history shifting, a long response stall and a random workload.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tovu_pkg::*;

   localparam int          HIST_LEN     = 7;
   localparam int          CNT_W        = 8;
   localparam int          RSP_W        = 88;
   localparam int          CLK_PERIOD   = 10;
   localparam int          RESET_CYCLES = 8;
   localparam int          IDLE_PCT     = 14;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          RANDOM_ITEMS = 380;
   localparam longint      CYCLE_LIMIT  = 400000;
   localparam int unsigned X_TOP        = 53760;
   localparam int unsigned Y_TOP        = 40960;

   localparam logic [CNT_W-1:0]    COUNT_MAX   = '1;
   localparam logic [CNT_W-1:0]    COUNT_ONE   = CNT_W'(1);
   localparam logic [HIST_LEN-1:0] HIST_NEWEST = HIST_LEN'(1) << (HIST_LEN - 1);

   // Response word layout, lowest bit up.
   localparam int PX_LO   = 0;
   localparam int PY_LO   = PX_LO + POS_W;
   localparam int VX_LO   = PY_LO + POS_W;
   localparam int VY_LO   = VX_LO + VEL_W;
   localparam int HIST_LO = VY_LO + VEL_W;
   localparam int CNT_LO  = HIST_LO + HIST_LEN;

   typedef struct packed {
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic [HIST_LEN-1:0]     history;
      logic [CNT_W-1:0]        frames_unseen;
   } track_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   // new_x, new_y, seen
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // kind
   logic                   req_tuser  = KIND_FRAME;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // pos_x, pos_y, vel_x, vel_y, history, frames_unseen
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   track_type track;
   track_type pending_tracks[$];
   int        fail_count  = 0;
   longint    cycle_count = 0;
   bit        steady      = 1'b0;
   int        hold_seq    = 0;
   int        hold_done   = 0;
   int        hold_left   = 0;

   tracked_object_velocity_update DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Position change over the frames since the last sighting, truncated
   // toward zero. A zero frame count is treated as one.
   function automatic logic signed [VEL_W-1:0] frame_velocity(
      input logic [POS_W-1:0] new_pos,
      input logic [POS_W-1:0] old_pos,
      input logic [CNT_W-1:0] frames
   );
      int diff;
      int divisor;
      diff    = int'(new_pos) - int'(old_pos);
      divisor = (frames == '0) ? 1 : int'(frames);
      return VEL_W'(diff / divisor);
   endfunction

   // Track state after one accepted request word.
   task automatic advance_track(
      input logic             kind,
      input logic [POS_W-1:0] new_x,
      input logic [POS_W-1:0] new_y,
      input logic             seen
   );
      if (kind == KIND_START) begin
         track.pos_x         = new_x;
         track.pos_y         = new_y;
         track.vel_x         = '0;
         track.vel_y         = '0;
         track.history       = HIST_NEWEST;
         track.frames_unseen = COUNT_ONE;
      end else begin
         track.history = (track.history >> 1) | (seen ? HIST_NEWEST : '0);
         if (seen) begin
            track.vel_x         = frame_velocity(new_x, track.pos_x, track.frames_unseen);
            track.vel_y         = frame_velocity(new_y, track.pos_y, track.frames_unseen);
            track.pos_x         = new_x;
            track.pos_y         = new_y;
            track.frames_unseen = COUNT_ONE;
         end else if (track.frames_unseen < COUNT_MAX) begin
            track.frames_unseen = track.frames_unseen + COUNT_ONE;
         end
      end
   endtask

   // Offer one request word, with random idle cycles ahead of it unless the
   // stream is meant to run without gaps. Valid stays high afterwards.
   task automatic send_word(
      input logic             kind,
      input logic [POS_W-1:0] new_x,
      input logic [POS_W-1:0] new_y,
      input logic             seen
   );
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({seen, new_y, new_x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_track(kind, new_x, new_y, seen);
      pending_tracks.push_back(track);
   endtask

   function automatic logic [POS_W-1:0] pick_pos(input int unsigned top);
      if ($urandom_range(9) == 0) return POS_W'($urandom);
      return POS_W'($urandom_range(top, 0));
   endfunction

   // Response side: random stalls, gapless stretches and a long hold-off
   // whenever the test sequence asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= hold_seq;
      end else if (hold_done != hold_seq) begin
         hold_done  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      track_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tracks.size() == 0) begin
            $error("response word arrived with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_tracks.pop_front();
            check_field("pos_x", int'(want.pos_x), int'(rsp_tdata[PX_LO +: POS_W]));
            check_field("pos_y", int'(want.pos_y), int'(rsp_tdata[PY_LO +: POS_W]));
            check_field("vel_x", int'($signed(want.vel_x)),
                        int'($signed(rsp_tdata[VX_LO +: VEL_W])));
            check_field("vel_y", int'($signed(want.vel_y)),
                        int'($signed(rsp_tdata[VY_LO +: VEL_W])));
            check_field("history", int'(want.history), int'(rsp_tdata[HIST_LO +: HIST_LEN]));
            check_field("frames_unseen", int'(want.frames_unseen),
                        int'(rsp_tdata[CNT_LO +: CNT_W]));
         end
      end
   end

   // Field extremes, negative and truncated velocities, starts with either
   // seen value and the oldest history bit falling off.
   task automatic test_directed();
      // An unseen update straight after reset shows the reset track.
      send_word(KIND_FRAME, 16'h1234, 16'h5678, 1'b0);
      send_word(KIND_FRAME, 16'hFFFF, 16'hFFFF, 1'b1);
      send_word(KIND_START, 16'hFFFF, 16'hFFFF, 1'b0);
      // Largest negative change.
      send_word(KIND_FRAME, 16'h0000, 16'h0000, 1'b1);
      send_word(KIND_START, POS_W'(X_TOP), POS_W'(Y_TOP), 1'b1);
      repeat (3) send_word(KIND_FRAME, 16'hAAAA, 16'h5555, 1'b0);
      send_word(KIND_FRAME, 16'h0000, 16'h0000, 1'b1);
      send_word(KIND_FRAME, POS_W'(X_TOP), POS_W'(Y_TOP), 1'b1);
      // Non-exact division in both directions truncates toward zero.
      repeat (2) send_word(KIND_FRAME, 16'h0000, 16'h0000, 1'b0);
      send_word(KIND_FRAME, POS_W'(X_TOP - 7), POS_W'(Y_TOP + 5), 1'b1);
      // Alternate seen flags long enough to push bits out of the history.
      for (int i = 0; i < 8; i++) begin
         send_word(KIND_FRAME, POS_W'(1000 + 37 * i), POS_W'(2000 - 29 * i), i[0]);
      end
      send_word(KIND_START, 16'h8000, 16'h7FFF, 1'b0);
      send_word(KIND_START, 16'h00FF, 16'hFF00, 1'b1);
   endtask

   // Enough unseen frames to pin the counter at its top, then a sighting
   // that divides by the saturated count.
   task automatic test_counter_saturation();
      send_word(KIND_START, 16'd1000, 16'd2000, 1'b1);
      for (int i = 0; i < 258; i++) begin
         send_word(KIND_FRAME, POS_W'($urandom), POS_W'($urandom), 1'b0);
      end
      send_word(KIND_FRAME, 16'd700, POS_W'(2000 + 255 * 3), 1'b1);
   endtask

   // The response side holds off for a long stretch while words keep coming,
   // so the block fills up and lowers req_tready.
   task automatic test_response_hold();
      hold_seq <= hold_seq + 1;
      send_word(KIND_START, pick_pos(X_TOP), pick_pos(Y_TOP), 1'b0);
      for (int i = 0; i < 30; i++) begin
         send_word(KIND_FRAME, pick_pos(X_TOP), pick_pos(Y_TOP), ($urandom_range(3) == 0));
      end
   endtask

   // Mostly tracks that start and then move in small steps with runs of
   // missed frames; the rest is unstructured noise. One stretch runs
   // without idle cycles on either side.
   task automatic test_random_tracks();
      int               sent;
      int               run_len;
      int               seen_pct;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady <= (sent >= 200) && (sent < 320);
         if ($urandom_range(99) < 85) begin
            x = pick_pos(X_TOP);
            y = pick_pos(Y_TOP);
            send_word(KIND_START, x, y, 1'($urandom));
            sent++;
            run_len  = $urandom_range(30, 3);
            seen_pct = $urandom_range(90, 20);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(99) < seen_pct) begin
                  x = x + POS_W'(int'($urandom_range(2048)) - 1024);
                  y = y + POS_W'(int'($urandom_range(2048)) - 1024);
                  send_word(KIND_FRAME, x, y, 1'b1);
               end else begin
                  send_word(KIND_FRAME, POS_W'($urandom), POS_W'($urandom), 1'b0);
               end
               sent++;
            end
         end else begin
            send_word(1'($urandom), POS_W'($urandom), POS_W'($urandom), 1'($urandom));
            sent++;
         end
      end
      steady <= 1'b0;
   endtask

   initial begin
      track.pos_x         = '0;
      track.pos_y         = '0;
      track.vel_x         = '0;
      track.vel_y         = '0;
      track.history       = HIST_NEWEST;
      track.frames_unseen = COUNT_ONE;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_counter_saturation();
      test_response_hold();
      test_random_tracks();

      // Let every outstanding response word arrive, then a short drain.
      req_tvalid <= 1'b0;
      while (pending_tracks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
